// ===== src/quaternion_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITH_UNIT_MACROS_SVH
`define QUATERNION_ARITH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define QAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("quaternion unit check failed");
`define QAU_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("quaternion unit forbidden condition");
`else
`define QAU_ASSERT(lbl, prop)
`define QAU_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== src/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Widths, types, operation codes and saturation helper of the quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    localparam int PROD_W = 2 * COMP_WIDTH;
    localparam int CLIP_W = 2 * COMP_WIDTH + 4;
    localparam int CSQ_W  = 2 * COMP_WIDTH - 1;
    localparam int NW     = 2 * COMP_WIDTH + 1;
    localparam int PW     = 2 * COMP_WIDTH + FRAC_BITS + 3;
    localparam int DW     = 2 * COMP_WIDTH + 2 * FRAC_BITS + 6;
    localparam int QW     = FRAC_BITS + 1;

    localparam int NRM_LAT = FRAC_BITS + 4;
    localparam int MUL_DLY = NRM_LAT - 2;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef comp_t quad_t [4];

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_NORM = 2'd1,
        OP_INV  = 2'd2
    } op_t;

    typedef struct packed {
        comp_t val;
        logic  sat;
    } clip_t;

    typedef struct packed {
        logic          neg;
        logic [QW-1:0] mag;
    } nrm_res_t;

    localparam logic signed [CLIP_W-1:0] COMP_MAX =
        {{(CLIP_W-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [CLIP_W-1:0] COMP_MIN = ~COMP_MAX;

    function automatic clip_t sat_comp(input logic signed [CLIP_W-1:0] v);
        clip_t r;
        if (v > COMP_MAX) begin
            r.val = COMP_MAX[COMP_WIDTH-1:0];
            r.sat = 1'b1;
        end
        else if (v < COMP_MIN) begin
            r.val = COMP_MIN[COMP_WIDTH-1:0];
            r.sat = 1'b1;
        end
        else begin
            r.val = v[COMP_WIDTH-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/qau_mul_lane.sv =====
// ----------------------------------------------------------------------------
// qau_mul_lane
// One Hamilton product component: four exact products, signed sum,
// round half up to the component format and saturate. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_mul_lane (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire qau_pkg::comp_t a [4],
    input  wire qau_pkg::comp_t b [4],
    input  wire logic [3:0]     neg,
    output qau_pkg::clip_t      res
);
    import qau_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [4];
    logic [3:0]               neg_reg;
    clip_t                    res_reg;

    logic signed [CLIP_W-1:0] sum;
    logic signed [CLIP_W-1:0] rnd;
    logic signed [CLIP_W-1:0] term;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= a[j] * b[j];
            end
            neg_reg <= neg;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int j = 0; j < 4; j++)
        begin
            term = CLIP_W'(prod_reg[j]);
            sum  = neg_reg[j] ? (sum - term) : (sum + term);
        end
        rnd = (sum + (CLIP_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= sat_comp(rnd);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== src/qau_nrm_lane.sv =====
// ----------------------------------------------------------------------------
// qau_nrm_lane
// One normalise component: square of the component, then one stage per
// quotient bit that finds the nearest |c| * 2^F / sqrt(N) with shift-add
// remainder updates only.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_nrm_lane (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire qau_pkg::comp_t        c,
    input  wire logic [qau_pkg::NW-1:0] norm,
    output logic [qau_pkg::CSQ_W-1:0]  csq,
    output qau_pkg::nrm_res_t          res
);
    import qau_pkg::*;

    localparam int ST = FRAC_BITS + 2;

    logic signed [PROD_W-1:0] sq;
    logic [CSQ_W-1:0]         csq0_reg;
    logic [CSQ_W-1:0]         csq1_reg;
    logic                     neg0_reg;
    logic                     neg1_reg;

    logic signed [DW-1:0] d_reg   [ST];
    logic signed [PW-1:0] p_reg   [ST];
    logic [NW-1:0]        n_reg   [ST];
    logic [QW-1:0]        q_reg   [ST];
    logic                 neg_reg [ST];

    assign sq = c * c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            csq0_reg <= sq[CSQ_W-1:0];
            neg0_reg <= c[COMP_WIDTH-1];
            csq1_reg <= csq0_reg;
            neg1_reg <= neg0_reg;
            d_reg[0]   <= (DW'(csq1_reg) << (2 * FRAC_BITS + 2)) - DW'(norm);
            p_reg[0]   <= -PW'(norm);
            n_reg[0]   <= norm;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg1_reg;
        end
    end

    for (genvar k = 0; k <= FRAC_BITS; k++)
    begin : g_bit
        localparam int B = FRAC_BITS - k;
        logic signed [DW-1:0] trial;
        logic                 take;

        always_comb
        begin
            trial = d_reg[k] - (DW'(p_reg[k]) <<< (B + 2))
                    - (DW'($signed({1'b0, n_reg[k]})) <<< (2 * B + 2));
            take  = !trial[DW-1] && !q_reg[k][FRAC_BITS];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k+1]   <= take ? trial : d_reg[k];
                p_reg[k+1]   <= take ? (p_reg[k] + (PW'(n_reg[k]) << (B + 1))) : p_reg[k];
                q_reg[k+1]   <= take ? (q_reg[k] | (QW'(1) << B)) : q_reg[k];
                n_reg[k+1]   <= n_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign csq = csq0_reg;
    assign res = {neg_reg[ST-1], q_reg[ST-1]};

endmodule

`default_nettype wire

// ===== src/quaternion_arith_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Q2.14 quaternion multiply, normalise and conjugate on four component lanes,
// merged into one saturated result with flags.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless stalled; normalise bit stages set depth.
// A stalled result holds the whole pipeline and stalls the input.
// Reset clears all valid flags; payload registers are not reset.
`default_nettype none
`include "quaternion_arith_unit_macros.svh"

module quaternion_arith_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire logic [1:0]     operation,
    input  wire qau_pkg::comp_t l_x,
    input  wire qau_pkg::comp_t l_y,
    input  wire qau_pkg::comp_t l_z,
    input  wire qau_pkg::comp_t l_w,
    input  wire qau_pkg::comp_t r_x,
    input  wire qau_pkg::comp_t r_y,
    input  wire qau_pkg::comp_t r_z,
    input  wire qau_pkg::comp_t r_w,
    output logic                result_valid,
    input  wire logic           result_stall,
    output qau_pkg::comp_t      out_x,
    output qau_pkg::comp_t      out_y,
    output qau_pkg::comp_t      out_z,
    output qau_pkg::comp_t      out_w,
    output logic                saturated,
    output logic                zero_norm
);
    import qau_pkg::*;

    localparam int LAST = NRM_LAT - 1;

    logic advance;

    quad_t      lq;
    quad_t      ma [4];
    quad_t      mb [4];
    logic [3:0] mneg [4];
    clip_t      mres [4];
    nrm_res_t   nres [4];
    logic [CSQ_W-1:0] csq [4];

    logic [NRM_LAT-1:0] vld_reg;
    logic [1:0]         op_reg   [NRM_LAT];
    quad_t              l_reg    [NRM_LAT];
    clip_t              mres_reg [MUL_DLY][4];
    logic               znd_reg  [MUL_DLY];
    logic [NW-1:0]      n_reg;

    logic  out_valid_reg;
    quad_t out_reg;
    logic  sat_reg;
    logic  zn_reg;

    quad_t res_next;
    logic  sat_next;
    logic  zn_next;
    clip_t cl;

    assign advance    = !(out_valid_reg && result_stall);
    assign item_stall = !advance;

    assign lq = '{l_x, l_y, l_z, l_w};

    assign ma[0] = '{l_w, l_x, l_y, l_z};
    assign mb[0] = '{r_x, r_w, r_z, r_y};
    assign mneg[0] = 4'b1000;
    assign ma[1] = '{l_w, l_x, l_y, l_z};
    assign mb[1] = '{r_y, r_z, r_w, r_x};
    assign mneg[1] = 4'b0010;
    assign ma[2] = '{l_w, l_x, l_y, l_z};
    assign mb[2] = '{r_z, r_y, r_x, r_w};
    assign mneg[2] = 4'b0100;
    assign ma[3] = '{l_w, l_x, l_y, l_z};
    assign mb[3] = '{r_w, r_x, r_y, r_z};
    assign mneg[3] = 4'b1110;

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        qau_mul_lane u_mul (
            .clk (clk),
            .en  (advance),
            .a   (ma[i]),
            .b   (mb[i]),
            .neg (mneg[i]),
            .res (mres[i])
        );

        qau_nrm_lane u_nrm (
            .clk  (clk),
            .en   (advance),
            .c    (lq[i]),
            .norm (n_reg),
            .csq  (csq[i]),
            .res  (nres[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[NRM_LAT-2:0], item_valid};
            out_valid_reg <= vld_reg[LAST];
        end
    end

    // advance payload along with the valid flags
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg[0] <= operation;
            l_reg[0]  <= lq;
            for (int s = 1; s < NRM_LAT; s++)
            begin
                op_reg[s] <= op_reg[s-1];
                l_reg[s]  <= l_reg[s-1];
            end
            n_reg <= NW'(csq[0]) + NW'(csq[1]) + NW'(csq[2]) + NW'(csq[3]);
            for (int i = 0; i < 4; i++)
            begin
                mres_reg[0][i] <= mres[i];
            end
            znd_reg[0] <= (n_reg == '0);
            for (int s = 1; s < MUL_DLY; s++)
            begin
                mres_reg[s] <= mres_reg[s-1];
                znd_reg[s]  <= znd_reg[s-1];
            end
            if (vld_reg[LAST])
            begin
                out_reg <= res_next;
                sat_reg <= sat_next;
                zn_reg  <= zn_next;
            end
        end
    end

    // merge lane results for the finishing operation
    always_comb
    begin
        res_next = '{default: '0};
        sat_next = 1'b0;
        zn_next  = 1'b0;
        cl       = '0;
        case (op_reg[LAST])
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_next[i] = mres_reg[MUL_DLY-1][i].val;
                    sat_next    = sat_next | mres_reg[MUL_DLY-1][i].sat;
                end
            end
            OP_NORM:
            begin
                if (znd_reg[MUL_DLY-1])
                begin
                    zn_next = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        cl = sat_comp(nres[i].neg ? -CLIP_W'(nres[i].mag)
                                                  : CLIP_W'(nres[i].mag));
                        res_next[i] = cl.val;
                        sat_next    = sat_next | cl.sat;
                    end
                end
            end
            OP_INV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cl = sat_comp(-CLIP_W'(l_reg[LAST][i]));
                    res_next[i] = cl.val;
                    sat_next    = sat_next | cl.sat;
                end
                res_next[3] = l_reg[LAST][3];
            end
            default:
            begin
                res_next = '{default: '0};
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign out_x        = out_reg[0];
    assign out_y        = out_reg[1];
    assign out_z        = out_reg[2];
    assign out_w        = out_reg[3];
    assign saturated    = sat_reg;
    assign zero_norm    = zn_reg;

    `QAU_ASSERT(a_zn_zero, (out_valid_reg && zn_reg) |-> (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
    `QAU_ASSERT_NEVER(a_zn_nosat, out_valid_reg && zn_reg && sat_reg)
    `QAU_ASSERT(a_fill, (advance && vld_reg[LAST]) |=> out_valid_reg)

endmodule

`default_nettype wire

// ===== tb/quaternion_result_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion result checker
// Watches both channels of the quaternion unit. For every input transfer it
// computes the expected result (Hamilton product, normalised left operand or
// conjugate, rounded and saturated). It compares every result transfer with
// the oldest expected result and counts the mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_result_checker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    input  wire logic  item_stall,
    input  wire logic [1:0] operation,
    input  qau_pkg::comp_t l_x,
    input  qau_pkg::comp_t l_y,
    input  qau_pkg::comp_t l_z,
    input  qau_pkg::comp_t l_w,
    input  qau_pkg::comp_t r_x,
    input  qau_pkg::comp_t r_y,
    input  qau_pkg::comp_t r_z,
    input  qau_pkg::comp_t r_w,
    input  wire logic  result_valid,
    input  wire logic  result_stall,
    input  qau_pkg::comp_t out_x,
    input  qau_pkg::comp_t out_y,
    input  qau_pkg::comp_t out_z,
    input  qau_pkg::comp_t out_w,
    input  wire logic  saturated,
    input  wire logic  zero_norm,
    output int         error_count,
    output int         pending_count
);
    import qau_pkg::*;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
        logic  sat;
        logic  zn;
    } quat_result_t;

    quat_result_t expected_results[$];

    function automatic comp_t clip_comp(input longint v, inout logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sd32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -16'sd32768;
        end
        return comp_t'(v);
    endfunction

    function automatic comp_t round_sum(input longint s, inout logic sat);
        longint r;
        r = (s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return clip_comp(r, sat);
    endfunction

    function automatic comp_t unit_comp(input longint c, input longint n, inout logic sat);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned cand;
        longint unsigned t;
        mag = (c < 0) ? -c : c;
        rhs = 128'(mag * mag) << (2 * FRAC_BITS + 2);
        q = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            if (cand <= (64'd1 << FRAC_BITS)) begin
                t = 2 * cand - 1;
                lhs = 128'(t * t) * 128'(n);
                if (lhs <= rhs)
                    q = cand;
            end
        end
        return clip_comp((c < 0) ? -longint'(q) : longint'(q), sat);
    endfunction

    function automatic quat_result_t quat_compute(input logic [1:0] op,
            input longint lx, input longint ly, input longint lz, input longint lw,
            input longint rx, input longint ry, input longint rz, input longint rw);
        quat_result_t e;
        logic sat;
        longint n;
        e = '0;
        sat = 1'b0;
        case (op)
            OP_MUL: begin
                e.x = round_sum(lw*rx + lx*rw + ly*rz - lz*ry, sat);
                e.y = round_sum(lw*ry - lx*rz + ly*rw + lz*rx, sat);
                e.z = round_sum(lw*rz + lx*ry - ly*rx + lz*rw, sat);
                e.w = round_sum(lw*rw - lx*rx - ly*ry - lz*rz, sat);
            end
            OP_NORM: begin
                n = lx*lx + ly*ly + lz*lz + lw*lw;
                if (n == 0)
                    e.zn = 1'b1;
                else begin
                    e.x = unit_comp(lx, n, sat);
                    e.y = unit_comp(ly, n, sat);
                    e.z = unit_comp(lz, n, sat);
                    e.w = unit_comp(lw, n, sat);
                end
            end
            OP_INV: begin
                e.x = clip_comp(-lx, sat);
                e.y = clip_comp(-ly, sat);
                e.z = clip_comp(-lz, sat);
                e.w = clip_comp(lw, sat);
            end
            default: ;
        endcase
        e.sat = sat;
        return e;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        quat_result_t e;
        if (!rst_n) begin
            error_count <= 0;
        end
        else begin
            if (item_valid && !item_stall)
                expected_results.push_back(quat_compute(operation, l_x, l_y, l_z, l_w,
                                                        r_x, r_y, r_z, r_w));
            if (result_valid && !result_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d",
                             $time, out_x, out_y, out_z, out_w);
                    error_count <= error_count + 1;
                end
                else begin
                    e = expected_results.pop_front();
                    if (e.x !== out_x || e.y !== out_y || e.z !== out_z || e.w !== out_w
                            || e.sat !== saturated || e.zn !== zero_norm) begin
                        $display("%0t: expected x=%0d y=%0d z=%0d w=%0d sat=%0b zn=%0b",
                                 $time, e.x, e.y, e.z, e.w, e.sat, e.zn);
                        $display("%0t: actual   x=%0d y=%0d z=%0d w=%0d sat=%0b zn=%0b",
                                 $time, out_x, out_y, out_z, out_w, saturated, zero_norm);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_quaternion_arith_unit.sv =====
// ----------------------------------------------------------------------------
// Quaternion unit testbench
// Sends directed corner items (extremes, zero norm, conjugate of the most
// negative value, unused code) and then random items with random idle bursts
// on the input and stall bursts on the result. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_arith_unit;
    import qau_pkg::*;

    localparam int NUM_RANDOM  = 430;
    localparam int CYCLE_LIMIT = 300000;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic [1:0] operation;
    comp_t      l_x, l_y, l_z, l_w;
    comp_t      r_x, r_y, r_z, r_w;
    logic       result_valid;
    logic       result_stall;
    comp_t      out_x, out_y, out_z, out_w;
    logic       saturated;
    logic       zero_norm;
    int         error_count;
    int         pending_count;
    logic       quiet_phase;
    int         cycle_count;

    quaternion_arith_unit u_dut (.*);
    quaternion_result_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // random stall bursts on the result side
    initial
    begin
        result_stall = 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            repeat ($urandom_range(1, 15)) @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 1))
                result_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            result_stall <= 1'b0;
        end
    end

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return comp_t'($urandom_range(0, 7)) - 16'sd4;
            default: return comp_t'($urandom);
        endcase
    endfunction

    task automatic send_quat(input logic [1:0] op, input comp_t a, input comp_t b,
                             input comp_t c, input comp_t d, input comp_t e,
                             input comp_t f, input comp_t g, input comp_t h);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        operation  <= op;
        l_x <= a; l_y <= b; l_z <= c; l_w <= d;
        r_x <= e; r_y <= f; r_z <= g; r_w <= h;
        item_valid <= 1'b1;
        do
            @(negedge clk);
        while (item_stall);
        @(posedge clk);
    endtask

    initial
    begin
        comp_t mx, mn;
        mx = 16'sd32767;
        mn = -16'sd32768;
        cycle_count = 0;
        quiet_phase = 1'b0;
        item_valid  = 1'b0;
        operation   = OP_MUL;
        {l_x, l_y, l_z, l_w, r_x, r_y, r_z, r_w} = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quat(OP_MUL, mx, mx, mx, mx, mx, mx, mx, mx);
        send_quat(OP_MUL, mn, mn, mn, mn, mn, mn, mn, mn);
        send_quat(OP_MUL, mn, mx, mn, mx, mx, mn, mx, mn);
        send_quat(OP_MUL, 0, 0, 0, 16'sd16384, 1, 2, 3, 16'sd16384);
        send_quat(OP_MUL, 1, 0, 0, 0, 16'sd8192, 0, 0, 0);
        send_quat(OP_MUL, -1, 0, 0, 0, 16'sd8192, 0, 0, 0);
        send_quat(OP_NORM, 0, 0, 0, 0, mx, mx, mx, mx);
        send_quat(OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0);
        send_quat(OP_NORM, 0, 0, 0, mn, 0, 0, 0, 0);
        send_quat(OP_NORM, mn, mn, mn, mn, 0, 0, 0, 0);
        send_quat(OP_NORM, mx, mx, mx, mx, 0, 0, 0, 0);
        send_quat(OP_NORM, 1, -1, 1, -1, 0, 0, 0, 0);
        send_quat(OP_NORM, 3, 4, 0, 0, 0, 0, 0, 0);
        send_quat(OP_INV, mn, mn, mn, mn, mx, mx, mx, mx);
        send_quat(OP_INV, mx, mx, mx, mx, mn, mn, mn, mn);
        send_quat(OP_INV, 1, -1, 0, mn, 0, 0, 0, 0);
        send_quat(2'd3, mx, mn, mx, mn, mx, mn, mx, mn);
        send_quat(2'd3, 0, 0, 0, 0, 0, 0, 0, 0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i > NUM_RANDOM - 60)
                quiet_phase <= 1'b1;
            send_quat(2'($urandom_range(0, 3)), rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        item_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
